@@ design/dsmp_pkg.sv @@
// Package for the decimal string modular power block: widths, register codes,
// command struct between front and back, and the queue depth.
`timescale 1ns / 1ps
package dsmp_pkg;
  localparam int MOD_W     = 32;
  localparam int EXP_W     = 64;
  localparam int RED_CNT_W = 7;    // holds 0..2*MOD_W
  localparam int QDEPTH    = 2;
  localparam int QIDX_W    = 1;
  localparam int QCNT_W    = 2;

  typedef enum logic [0:0] {
    REG_MODULUS  = 1'b0,
    REG_EXPONENT = 1'b1
  } reg_idx_t;

  // Command from front to back: a finished number residue.
  typedef struct packed {
    logic [MOD_W-1:0] residue;
  } cmd_t;
endpackage

@@ design/dsmp_modred.sv @@
// Sequential modular reduction: a 64-bit value mod a 32-bit modulus by
// restoring shift-subtract, one quotient bit per cycle. Depends on dsmp_pkg.
`timescale 1ns / 1ps
module dsmp_modred import dsmp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2*MOD_W-1:0]   dividend,
  input  logic [MOD_W-1:0]     modulus,
  output logic                 done,
  output logic [MOD_W-1:0]     remainder
);
  logic                busy_r, busy_nxt;
  logic [RED_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2*MOD_W-1:0]  dvd_r, dvd_nxt;
  logic [MOD_W:0]      rem_r, rem_nxt;
  logic                done_r, done_nxt;
  logic [MOD_W:0]      shifted;

  assign shifted   = {rem_r[MOD_W-1:0], dvd_r[2*MOD_W-1]};
  assign done      = done_r;
  assign remainder = rem_r[MOD_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = RED_CNT_W'(2*MOD_W);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (shifted >= {1'b0, modulus}) rem_nxt = shifted - {1'b0, modulus};
      else rem_nxt = shifted;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == RED_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end
endmodule

@@ design/dsmp_front.sv @@
// Front end: takes digits, keeps the running residue, pushes a command for
// each finished number. Depends on dsmp_pkg and dsmp_modred.
`timescale 1ns / 1ps
module dsmp_front import dsmp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0]       in_digit,
  input  logic             in_last_digit,
  input  logic [MOD_W-1:0] modulus,
  output logic             cmd_valid,
  input  logic             cmd_full,
  output cmd_t             cmd
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_RED  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t          st_r, st_nxt;
  logic [MOD_W-1:0] res_r, res_nxt;
  logic             last_r, last_nxt;
  logic             red_start, red_done;
  logic [MOD_W-1:0] red_rem;
  logic [2*MOD_W-1:0] dvd;

  assign in_stall  = (st_r != F_IDLE);
  // residue < modulus always, so res*10+digit fits 36 bits
  assign dvd       = (2*MOD_W)'(res_r) * (2*MOD_W)'(10) + (2*MOD_W)'(in_digit);
  assign red_start = in_valid && (st_r == F_IDLE);
  assign cmd_valid = (st_r == F_PUSH);
  assign cmd.residue = res_r;

  dsmp_modred u_red (
    .clk(clk), .rst_n(rst_n), .start(red_start), .dividend(dvd),
    .modulus(modulus), .done(red_done), .remainder(red_rem)
  );

  always_comb begin
    st_nxt   = st_r;
    res_nxt  = res_r;
    last_nxt = last_r;
    unique case (st_r)
      F_IDLE: if (in_valid) begin
        last_nxt = in_last_digit;
        st_nxt   = F_RED;
      end
      F_RED: if (red_done) begin
        res_nxt = red_rem;
        st_nxt  = last_r ? F_PUSH : F_IDLE;
      end
      F_PUSH: if (!cmd_full) begin
        res_nxt = '0;
        st_nxt  = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      res_r  <= '0;
      last_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      res_r  <= res_nxt;
      last_r <= last_nxt;
    end
  end
endmodule

@@ design/dsmp_back.sv @@
// Back end: square-and-multiply power over the exponent bits, with one
// shared reducer, and an output register. Depends on dsmp_pkg, dsmp_modred.
`timescale 1ns / 1ps
module dsmp_back import dsmp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  input  cmd_t             cmd,
  input  logic [MOD_W-1:0] modulus,
  input  logic [EXP_W-1:0] exponent,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [MOD_W-1:0] out_number_residue,
  output logic [MOD_W-1:0] out_power_residue
);
  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_INIT  = 6'b000010,
    B_MUL   = 6'b000100,
    B_SQR   = 6'b001000,
    B_WAIT  = 6'b010000,
    B_OUT   = 6'b100000
  } bstate_t;

  bstate_t          st_r, st_nxt, ret_r, ret_nxt;
  logic [MOD_W-1:0] num_r, num_nxt, base_r, base_nxt, acc_r, acc_nxt;
  logic [EXP_W-1:0] exp_r, exp_nxt;
  logic             ov_r, ov_nxt;
  logic [MOD_W-1:0] onum_r, onum_nxt, opow_r, opow_nxt;
  logic             red_start, red_done;
  logic [MOD_W-1:0] red_rem;
  logic [2*MOD_W-1:0] dvd_r, dvd_nxt;
  logic [1:0]       tgt_r, tgt_nxt;   // 0 base, 1 acc (also used for acc init)
  logic             startq_r, startq_nxt;

  assign red_start = startq_r;
  assign out_valid = ov_r;
  assign out_number_residue = onum_r;
  assign out_power_residue  = opow_r;
  assign cmd_pop = (st_r == B_IDLE) && cmd_valid;

  dsmp_modred u_red (
    .clk(clk), .rst_n(rst_n), .start(red_start), .dividend(dvd_r),
    .modulus(modulus), .done(red_done), .remainder(red_rem)
  );

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; num_nxt = num_r; base_nxt = base_r;
    acc_nxt = acc_r; exp_nxt = exp_r; ov_nxt = ov_r; onum_nxt = onum_r;
    opow_nxt = opow_r; dvd_nxt = dvd_r; tgt_nxt = tgt_r; startq_nxt = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      B_IDLE: if (cmd_valid) begin
        num_nxt  = cmd.residue;
        base_nxt = cmd.residue;
        exp_nxt  = exponent;
        if (exponent == '0) begin
          acc_nxt = MOD_W'(1);
          st_nxt  = B_OUT;
        end else begin
          // acc = 1 mod m
          dvd_nxt = (2*MOD_W)'(1);
          tgt_nxt = 2'd1;
          startq_nxt = 1'b1;
          ret_nxt = B_MUL;
          st_nxt  = B_WAIT;
        end
      end
      B_MUL: begin
        if (exp_r == '0) st_nxt = B_OUT;
        else if (exp_r[0]) begin
          dvd_nxt = (2*MOD_W)'(acc_r) * (2*MOD_W)'(base_r);
          tgt_nxt = 2'd1;
          startq_nxt = 1'b1;
          ret_nxt = B_SQR;
          st_nxt  = B_WAIT;
        end else st_nxt = B_SQR;
      end
      B_SQR: begin
        dvd_nxt = (2*MOD_W)'(base_r) * (2*MOD_W)'(base_r);
        tgt_nxt = 2'd0;
        startq_nxt = 1'b1;
        exp_nxt = exp_r >> 1;
        ret_nxt = B_MUL;
        st_nxt  = B_WAIT;
      end
      B_WAIT: if (red_done) begin
        if (tgt_r == 2'd0) base_nxt = red_rem;
        else acc_nxt = red_rem;
        st_nxt = ret_r;
      end
      B_OUT: if (!ov_r || !out_stall) begin
        ov_nxt   = 1'b1;
        onum_nxt = num_r;
        opow_nxt = acc_r;
        st_nxt   = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ret_r <= B_IDLE;
      ov_r <= 1'b0;
      startq_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ret_r <= ret_nxt;
      ov_r <= ov_nxt;
      startq_r <= startq_nxt;
    end
    num_r <= num_nxt; base_r <= base_nxt; acc_r <= acc_nxt; exp_r <= exp_nxt;
    onum_r <= onum_nxt; opow_r <= opow_nxt; dvd_r <= dvd_nxt; tgt_r <= tgt_nxt;
  end
endmodule

@@ design/dsmp_queue.sv @@
// Short command queue between front and back ends. Depends on dsmp_pkg.
`timescale 1ns / 1ps
module dsmp_queue import dsmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t pop_data
);
  cmd_t              mem_r [QDEPTH];
  logic [QIDX_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign pop_data = mem_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
    if (do_push) mem_r[wp_r] <= push_data;
  end
endmodule

@@ design/decimal_string_modular_power.sv @@
// Top level of the decimal string modular power block: config registers,
// front end, command queue and back end. Depends on dsmp_pkg and submodules.
//
// Usage: digits enter on in_valid/in_stall, most significant first, one beat
// per digit; in_last_digit ends a number. After a digit beat in_stall stays
// high while the bit-serial reducer (64 steps) computes (r*10+d) mod m, and
// for a last digit also until the residue is pushed into the queue, so the
// next digit is taken only after that.
// A last digit sends the residue into a two-entry queue; the back end then
// runs square and multiply through its own bit-serial reducer, shared by all
// its products: first 1 mod m, then per exponent bit a multiply if the bit
// is set and a square, then the output load; exponent 0 gives power 1.
// One result beat (number_residue, power_residue) leaves on out_valid/
// out_stall; an output register holds it while the receiver stalls, and the
// back end waits, the queue fills, then the front end stalls its input.
// Reset clears all control; modulus resets to 1, exponent to 0; modulus 0
// acts as 1. Configuration is written via cfg_valid/cfg_ready, cfg_index
// 0 modulus, 1 exponent, by the user only while idle; the block won't check.
`timescale 1ns / 1ps
module decimal_string_modular_power import dsmp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0]       in_digit,
  input  logic             in_last_digit,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [MOD_W-1:0] out_number_residue,
  output logic [MOD_W-1:0] out_power_residue,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [EXP_W-1:0] cfg_data
);
  logic [MOD_W-1:0] mod_r;
  logic [EXP_W-1:0] exp_r;
  logic [MOD_W-1:0] eff_mod;
  logic             f_valid, q_full, q_nonempty, q_pop;
  cmd_t             f_cmd, q_cmd;

  assign cfg_ready = 1'b1;
  assign eff_mod   = (mod_r == '0) ? MOD_W'(1) : mod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_W'(1);
      exp_r <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODULUS:  mod_r <= cfg_data[MOD_W-1:0];
        REG_EXPONENT: exp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dsmp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_digit(in_digit), .in_last_digit(in_last_digit), .modulus(eff_mod),
    .cmd_valid(f_valid), .cmd_full(q_full), .cmd(f_cmd)
  );

  dsmp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(f_valid), .push_data(f_cmd),
    .full(q_full), .pop(q_pop), .nonempty(q_nonempty), .pop_data(q_cmd)
  );

  dsmp_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_nonempty), .cmd_pop(q_pop),
    .cmd(q_cmd), .modulus(eff_mod), .exponent(exp_r), .out_valid(out_valid),
    .out_stall(out_stall), .out_number_residue(out_number_residue),
    .out_power_residue(out_power_residue)
  );
endmodule

@@ test/tb_decimal_string_modular_power.sv @@
// Testbench for decimal_string_modular_power: digit beats in, residue and modular
// power out, checked against an in-bench square and multiply predictor.
// Depends on dsmp_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_decimal_string_modular_power;
  import dsmp_pkg::*;

  localparam int LIMIT_CYCLES = 20000000;
  localparam int SETTLE_CYCLES = 200;  // one digit reduction plus margin

  typedef struct packed {
    logic [MOD_W-1:0] number_residue;
    logic [MOD_W-1:0] power_residue;
  } result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [3:0]       in_digit;
  logic             in_last_digit;
  logic             out_valid;
  logic             out_stall;
  logic [MOD_W-1:0] out_number_residue;
  logic [MOD_W-1:0] out_power_residue;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [EXP_W-1:0] cfg_data;

  decimal_string_modular_power dut (.*);

  // predictor state
  bit [MOD_W-1:0] modulus_reg;
  bit [EXP_W-1:0] exponent_reg;
  bit [63:0]      digit_residue;
  result_t        expected_results[$];

  bit failed;
  bit no_idle;
  bit hold_long;
  int cycle_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit [63:0] eff_modulus();
    return (modulus_reg == '0) ? 64'd1 : 64'(modulus_reg);
  endfunction

  function automatic bit [63:0] power_mod(bit [63:0] base, bit [EXP_W-1:0] e,
                                          bit [63:0] m);
    bit [63:0] acc;
    if (e == '0) return 64'd1;
    acc = 64'd1 % m;
    base = base % m;
    while (e != '0) begin
      if (e[0]) acc = (acc * base) % m;
      base = (base * base) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  // advance the running residue; queue a result on a last digit
  function automatic void predict_digit(bit [3:0] d, bit last);
    bit [63:0] m;
    result_t r;
    m = eff_modulus();
    digit_residue = ((digit_residue % m) * 64'd10 + 64'(d)) % m;
    if (last) begin
      r.number_residue = digit_residue[MOD_W-1:0];
      r.power_residue  = MOD_W'(power_mod(digit_residue, exponent_reg, m));
      expected_results = {expected_results, r};
      digit_residue = '0;
    end
  endfunction

  task automatic send_digit(bit [3:0] d, bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_digit      <= d;
    in_last_digit <= last;
    do @(posedge clk); while (in_stall);
    predict_digit(d, last);
  endtask

  // block idle: no beat in flight, nothing owed, reducer done
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [EXP_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MODULUS) modulus_reg = value[MOD_W-1:0];
    else exponent_reg = value;
  endtask

  task automatic set_config(bit [MOD_W-1:0] m, bit [EXP_W-1:0] e);
    wait_idle();
    write_reg(REG_MODULUS, 64'(m));
    write_reg(REG_EXPONENT, e);
  endtask

  // receiver: random stall before each beat (none when no_idle), one long hold on request
  initial begin
    int n;
    out_stall = 1'b1;
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        n = 3000;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 16);
      end
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected beat: number %0d power %0d", $time,
                 out_number_residue, out_power_residue);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (out_number_residue !== want.number_residue) begin
          $display("%0t number_residue expected %0d actual %0d", $time,
                   want.number_residue, out_number_residue);
          failed = 1'b1;
        end
        if (out_power_residue !== want.power_residue) begin
          $display("%0t power_residue expected %0d actual %0d", $time,
                   want.power_residue, out_power_residue);
          failed = 1'b1;
        end
      end
    end
  end

  // defaults: modulus 1, exponent 0 -> residue 0, power 1
  task automatic test_reset_defaults();
    send_digit(4'd7, 1'b0);
    send_digit(4'd3, 1'b1);
    send_digit(4'd0, 1'b1);
  endtask

  task automatic test_directed();
    set_config(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_digit(4'd9, 1'b0);
    send_digit(4'd9, 1'b0);
    send_digit(4'd9, 1'b0);
    send_digit(4'd9, 1'b1);
    set_config(32'd1000003, 64'd5);
    send_digit(4'd15, 1'b0);  // digits above nine pass through as values
    send_digit(4'd10, 1'b0);
    send_digit(4'd12, 1'b1);
    send_digit(4'd0, 1'b1);   // zero residue
    set_config(32'd1, 64'd3); // modulus one, nonzero exponent
    send_digit(4'd8, 1'b1);
    set_config(32'd1, 64'd0); // modulus one, exponent zero
    send_digit(4'd4, 1'b1);
    set_config(32'd0, 64'd9); // modulus zero acts as one
    send_digit(4'd6, 1'b1);
    set_config(32'd2, 64'd1);
    send_digit(4'd1, 1'b1);
    send_digit(4'd5, 1'b0);
    send_digit(4'd4, 1'b1);
    set_config(32'd7, 64'd0);
    send_digit(4'd9, 1'b1);
  endtask

  task automatic test_backpressure();
    set_config(32'd97, 64'd13);
    hold_long = 1'b1;
    for (int i = 0; i < 12; i++) send_digit(4'($urandom_range(0, 9)), 1'b1);
  endtask

  task automatic test_random();
    bit [MOD_W-1:0] m;
    bit [EXP_W-1:0] e;
    int bits;
    int left;
    bit [3:0] d;
    for (int phase = 0; phase < 13; phase++) begin
      case ($urandom_range(0, 4))
        0: m = 32'd1;
        1: m = 32'd2;
        2: m = 32'hFFFF_FFFF;
        3: m = $urandom_range(2, 1000);
        default: m = $urandom;
      endcase
      bits = (phase == 12) ? 64 : $urandom_range(0, 12);
      e = {$urandom, $urandom};
      if (bits == 0) e = '0;
      else begin
        e = e >> (64 - bits);
        e[bits-1] = 1'b1;
      end
      set_config(m, e);
      no_idle = (phase % 4 == 1);
      for (int i = 0; i < 100; i++) begin
        d = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
        if (i == 99) send_digit(d, 1'b1);
        else if (phase == 12) send_digit(d, $urandom_range(0, 19) == 0);
        else send_digit(d, $urandom_range(0, 3) == 0);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_digit = '0;
    in_last_digit = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    modulus_reg = 32'd1;
    exponent_reg = '0;
    digit_residue = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random();

    wait_idle();
    if (!failed) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

@@ sim.f @@
design/dsmp_pkg.sv
design/dsmp_modred.sv
design/dsmp_front.sv
design/dsmp_back.sv
design/dsmp_queue.sv
design/decimal_string_modular_power.sv
test/tb_decimal_string_modular_power.sv
